// ===== hw/rtl/lsps_pkg.sv =====
// types, constants and helpers shared by the line sensor steering block
package lsps_pkg;

    localparam int NUM_SENSORS  = 14;
    localparam int SAMPLE_BITS  = 10;

    localparam int Q12_ONE      = 4096;
    localparam int FULL_PERCENT = 100;
    localparam int EDGE_SPAN    = 3;
    localparam int HALF         = NUM_SENSORS / 2;
    localparam int EDGE_POS     = HALF * FULL_PERCENT;

    localparam int GAIN_W       = 16;
    localparam int MARGIN_W     = 10;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;

    localparam int DRIVE_W      = 16;
    localparam int POS_W        = 11;
    localparam int SCNT_W       = $clog2(NUM_SENSORS);
    localparam int WGT_W        = 5;
    localparam int WSUM_W       = 13;
    localparam int FSUM_W       = $clog2(NUM_SENSORS * Q12_ONE + 1);
    localparam int FRAC_W       = 13;
    localparam int PCT_W        = 7;
    localparam int FRAC_Q_W     = 12;
    localparam int POS_Q_W      = 11;
    localparam int DIV_W        = FSUM_W;
    localparam int DCNT_W       = 4;
    localparam int THR_W        = ((SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W) + 1;
    localparam int P100_W       = SAMPLE_BITS + PCT_W;
    localparam int ACC_W        = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 2'd0,
        REG_DERIV_GAIN  = 2'd1,
        REG_LOW_MARGIN  = 2'd2,
        REG_HIGH_MARGIN = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_FRAC,
        S_PCT_INIT,
        S_PCT,
        S_ACCUM,
        S_FRAME,
        S_POS,
        S_POS_DONE,
        S_MUL_P,
        S_MUL_D,
        S_FINISH
    } state_t;

    function automatic logic signed [WGT_W-1:0] weight_of(input logic [SCNT_W-1:0] idx);
        int i;
        int lo;
        int hi;
        i  = int'(idx);
        lo = NUM_SENSORS / 2;
        hi = (NUM_SENSORS + 1) / 2;
        if (i < lo)
        begin
            return WGT_W'(i - lo);
        end
        if (i < hi)
        begin
            return '0;
        end
        return WGT_W'(i - hi + 1);
    endfunction

endpackage

// ===== hw/rtl/lsps_if.sv =====
// item channels of the line sensor steering block

interface lsps_sensor_if;
    logic                              valid;
    logic                              ready;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  sample;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  cal_min;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  cal_max;

    modport source (output valid, output sample, output cal_min, output cal_max, input ready);
    modport sink   (input valid, input sample, input cal_min, input cal_max, output ready);
endinterface

interface lsps_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [lsps_pkg::DRIVE_W-1:0] drive;
    logic signed [lsps_pkg::POS_W-1:0]   position;
    logic                                line_seen;

    modport source (output valid, output drive, output position, output line_seen, input ready);
    modport sink   (input valid, input drive, input position, input line_seen, output ready);
endinterface

// ===== hw/rtl/line_sensor_pd_steering.sv =====
// line sensor centroid with pd steering output, one shared divider and multiplier
//
//  channel   dir   handshake          payload
//  sensor    in    valid / ready      sample, cal_min, cal_max
//  result    out   valid / ready      drive, position, line_seen
//  config    in    wr_en              wr_index, wr_data
//
//  a sample in the middle band passes through the shared restoring
//  divider (12 steps for the fraction, 7 for the percent); a clipped sample skips it
//  the last sample of a frame adds the position divide
//  and the two passes through the shared multiplier
//  reset clears the frame sums and edge flags, sets the line flag and loads the register defaults
//  a held result stalls the frame end and with it the next frame's samples

module line_sensor_pd_steering
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [lsps_pkg::CFG_DATA_W-1:0]     wr_data,
    lsps_sensor_if.sink                         sensor,
    lsps_result_if.source                       result
);

    localparam int SB = lsps_pkg::SAMPLE_BITS;

    // configuration
    logic [lsps_pkg::GAIN_W-1:0]    prop_gain_reg;
    logic [lsps_pkg::GAIN_W-1:0]    deriv_gain_reg;
    logic [lsps_pkg::MARGIN_W-1:0]  low_margin_reg;
    logic [lsps_pkg::MARGIN_W-1:0]  high_margin_reg;

    // control and frame state
    lsps_pkg::state_t                   state_reg, state_next;
    logic [lsps_pkg::SCNT_W-1:0]        scount_reg;
    logic signed [lsps_pkg::WSUM_W-1:0] wsum_reg;
    logic [lsps_pkg::FSUM_W-1:0]        fsum_reg;
    logic                               left_now_reg, right_now_reg;
    logic                               left_before_reg, right_before_reg;
    logic                               on_line_reg;
    logic signed [lsps_pkg::POS_W-1:0]  prev_pos_reg;
    logic                               res_valid_reg;

    // working registers
    logic [SB-1:0]                      samp_reg, min_reg, max_reg;
    logic [lsps_pkg::DIV_W-1:0]         rem_reg, divisor_reg;
    logic [lsps_pkg::PCT_W-1:0]         dvd_reg;
    logic [lsps_pkg::FRAC_Q_W-1:0]      quo_reg;
    logic [lsps_pkg::DCNT_W-1:0]        cnt_reg;
    logic [lsps_pkg::FRAC_W-1:0]        frac_reg;
    logic [lsps_pkg::PCT_W-1:0]         pct_reg;
    logic signed [lsps_pkg::POS_W-1:0]  pos_reg;
    logic signed [lsps_pkg::ACC_W-1:0]  acc_reg;

    // result registers
    logic signed [lsps_pkg::DRIVE_W-1:0] res_drive_reg;
    logic signed [lsps_pkg::POS_W-1:0]   res_pos_reg;
    logic                                res_seen_reg;

    // control decode
    logic accept;
    logic div_step;
    logic out_load;

    // classification
    logic          zero_hit, full_hit;
    logic [SB-1:0] d_val, r_val;
    logic [lsps_pkg::P100_W-1:0] p100;

    // shared divider step
    logic [lsps_pkg::DIV_W:0]   trial_a;
    logic [lsps_pkg::DIV_W-1:0] trial_b;
    logic [lsps_pkg::DIV_W+1:0] trial_diff;
    logic                       take;
    logic [lsps_pkg::FRAC_Q_W-1:0] quo_step;

    // frame end
    logic                               ws_neg;
    logic [lsps_pkg::WSUM_W-1:0]        ws_mag;
    logic [lsps_pkg::POS_Q_W-1:0]       pos_q;
    logic signed [lsps_pkg::POS_W-1:0]  pos_div;
    logic signed [lsps_pkg::WSUM_W-1:0] w_ext, pct_ext, w_add;
    logic                               last_sensor;

    // shared multiplier and drive
    logic signed [lsps_pkg::POS_W:0]    mul_a;
    logic signed [lsps_pkg::GAIN_W:0]   mul_b;
    logic signed [lsps_pkg::ACC_W-1:0]  product;
    logic signed [lsps_pkg::ACC_W-1:0]  acc_adj, acc_shr;
    logic signed [lsps_pkg::DRIVE_W-1:0] drive_sat;

    localparam logic signed [lsps_pkg::ACC_W-1:0] DRV_MAX = lsps_pkg::ACC_W'(32767);
    localparam logic signed [lsps_pkg::ACC_W-1:0] DRV_MIN = lsps_pkg::ACC_W'(-32768);
    localparam logic signed [lsps_pkg::ACC_W-1:0] RND_ADD = lsps_pkg::ACC_W'(255);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= lsps_pkg::GAIN_W'(256);
            deriv_gain_reg  <= lsps_pkg::GAIN_W'(128);
            low_margin_reg  <= lsps_pkg::MARGIN_W'(150);
            high_margin_reg <= lsps_pkg::MARGIN_W'(25);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                lsps_pkg::REG_PROP_GAIN:   prop_gain_reg   <= wr_data[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::REG_DERIV_GAIN:  deriv_gain_reg  <= wr_data[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::REG_LOW_MARGIN:  low_margin_reg  <= wr_data[lsps_pkg::MARGIN_W-1:0];
                lsps_pkg::REG_HIGH_MARGIN: high_margin_reg <= wr_data[lsps_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // sample classification
    always_comb
    begin
        zero_hit = lsps_pkg::THR_W'(samp_reg)
                   <= lsps_pkg::THR_W'(min_reg) + lsps_pkg::THR_W'(low_margin_reg);
        full_hit = lsps_pkg::THR_W'(samp_reg) + lsps_pkg::THR_W'(high_margin_reg)
                   >= lsps_pkg::THR_W'(max_reg);
        d_val    = samp_reg - min_reg;
        r_val    = max_reg - min_reg;
        p100     = lsps_pkg::P100_W'(d_val) * lsps_pkg::P100_W'(lsps_pkg::FULL_PERCENT);
    end

    // frame end helpers
    always_comb
    begin
        ws_neg  = wsum_reg[lsps_pkg::WSUM_W-1];
        ws_mag  = ws_neg ? lsps_pkg::WSUM_W'(-wsum_reg) : lsps_pkg::WSUM_W'(wsum_reg);
        pos_q   = quo_reg[lsps_pkg::POS_Q_W-1:0];
        if (ws_neg)
        begin
            pos_div = (pos_q > lsps_pkg::POS_Q_W'(1024))
                      ? lsps_pkg::POS_W'(-1024) : -$signed(pos_q);
        end
        else
        begin
            pos_div = (pos_q > lsps_pkg::POS_Q_W'(1023))
                      ? lsps_pkg::POS_W'(1023) : $signed(pos_q);
        end
        w_ext       = lsps_pkg::WSUM_W'(lsps_pkg::weight_of(scount_reg));
        pct_ext     = $signed(lsps_pkg::WSUM_W'(pct_reg));
        w_add       = pct_ext * w_ext;
        last_sensor = scount_reg == lsps_pkg::SCNT_W'(lsps_pkg::NUM_SENSORS - 1);
    end

    // shared compare and subtract
    always_comb
    begin
        if (state_reg == lsps_pkg::S_FRAME)
        begin
            trial_a = (lsps_pkg::DIV_W+1)'({ws_mag, 1'b0});
            trial_b = fsum_reg;
        end
        else
        begin
            trial_a = {rem_reg, dvd_reg[lsps_pkg::PCT_W-1]};
            trial_b = divisor_reg;
        end
        trial_diff = {1'b0, trial_a} - {2'b00, trial_b};
        take       = !trial_diff[lsps_pkg::DIV_W+1];
        quo_step   = {quo_reg[lsps_pkg::FRAC_Q_W-2:0], take};
    end

    // shared multiplier and drive scaling
    always_comb
    begin
        if (state_reg == lsps_pkg::S_MUL_P)
        begin
            mul_a = {pos_reg[lsps_pkg::POS_W-1], pos_reg};
            mul_b = $signed({1'b0, prop_gain_reg});
        end
        else
        begin
            mul_a = {pos_reg[lsps_pkg::POS_W-1], pos_reg}
                    - {prev_pos_reg[lsps_pkg::POS_W-1], prev_pos_reg};
            mul_b = $signed({1'b0, deriv_gain_reg});
        end
        product = mul_a * mul_b;
        acc_adj = acc_reg[lsps_pkg::ACC_W-1] ? acc_reg + RND_ADD : acc_reg;
        acc_shr = acc_adj >>> 8;
        if (acc_shr > DRV_MAX)
        begin
            drive_sat = lsps_pkg::DRIVE_W'(DRV_MAX);
        end
        else if (acc_shr < DRV_MIN)
        begin
            drive_sat = lsps_pkg::DRIVE_W'(DRV_MIN);
        end
        else
        begin
            drive_sat = acc_shr[lsps_pkg::DRIVE_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsps_pkg::S_IDLE:
                if (sensor.valid)
                begin
                    state_next = lsps_pkg::S_CLASS;
                end
            lsps_pkg::S_CLASS:
                state_next = (zero_hit || full_hit) ? lsps_pkg::S_ACCUM : lsps_pkg::S_FRAC;
            lsps_pkg::S_FRAC:
                if (cnt_reg == lsps_pkg::DCNT_W'(1))
                begin
                    state_next = lsps_pkg::S_PCT_INIT;
                end
            lsps_pkg::S_PCT_INIT:
                state_next = lsps_pkg::S_PCT;
            lsps_pkg::S_PCT:
                if (cnt_reg == lsps_pkg::DCNT_W'(1))
                begin
                    state_next = lsps_pkg::S_ACCUM;
                end
            lsps_pkg::S_ACCUM:
                state_next = last_sensor ? lsps_pkg::S_FRAME : lsps_pkg::S_IDLE;
            lsps_pkg::S_FRAME:
                if (fsum_reg == '0)
                begin
                    state_next = lsps_pkg::S_MUL_P;
                end
                else
                begin
                    state_next = take ? lsps_pkg::S_POS_DONE : lsps_pkg::S_POS;
                end
            lsps_pkg::S_POS:
                if (cnt_reg == lsps_pkg::DCNT_W'(1))
                begin
                    state_next = lsps_pkg::S_POS_DONE;
                end
            lsps_pkg::S_POS_DONE:
                state_next = lsps_pkg::S_MUL_P;
            lsps_pkg::S_MUL_P:
                state_next = lsps_pkg::S_MUL_D;
            lsps_pkg::S_MUL_D:
                state_next = lsps_pkg::S_FINISH;
            lsps_pkg::S_FINISH:
                if (out_load)
                begin
                    state_next = lsps_pkg::S_IDLE;
                end
            default:
                state_next = lsps_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        sensor.ready = state_reg == lsps_pkg::S_IDLE;
        accept       = sensor.valid && (state_reg == lsps_pkg::S_IDLE);
        div_step     = (state_reg == lsps_pkg::S_FRAC) || (state_reg == lsps_pkg::S_PCT)
                       || (state_reg == lsps_pkg::S_POS);
        out_load     = (state_reg == lsps_pkg::S_FINISH) && (!res_valid_reg || result.ready);
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lsps_pkg::S_IDLE;
            scount_reg       <= '0;
            wsum_reg         <= '0;
            fsum_reg         <= '0;
            left_now_reg     <= 1'b0;
            right_now_reg    <= 1'b0;
            left_before_reg  <= 1'b0;
            right_before_reg <= 1'b0;
            on_line_reg      <= 1'b1;
            prev_pos_reg     <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == lsps_pkg::S_ACCUM)
            begin
                wsum_reg   <= wsum_reg + w_add;
                fsum_reg   <= fsum_reg + lsps_pkg::FSUM_W'(frac_reg);
                scount_reg <= scount_reg + lsps_pkg::SCNT_W'(1);
                if (frac_reg != '0)
                begin
                    if (int'(scount_reg) < lsps_pkg::EDGE_SPAN)
                    begin
                        left_now_reg <= 1'b1;
                    end
                    if (int'(scount_reg) + lsps_pkg::EDGE_SPAN >= lsps_pkg::NUM_SENSORS)
                    begin
                        right_now_reg <= 1'b1;
                    end
                end
            end

            if ((state_reg == lsps_pkg::S_FRAME) && (fsum_reg == '0) && on_line_reg
                && (left_before_reg || right_before_reg))
            begin
                on_line_reg <= 1'b0;
            end

            if (state_reg == lsps_pkg::S_POS_DONE)
            begin
                on_line_reg <= 1'b1;
            end

            if (out_load)
            begin
                res_valid_reg    <= 1'b1;
                prev_pos_reg     <= pos_reg;
                left_before_reg  <= left_now_reg;
                right_before_reg <= right_now_reg;
                left_now_reg     <= 1'b0;
                right_now_reg    <= 1'b0;
                wsum_reg         <= '0;
                fsum_reg         <= '0;
                scount_reg       <= '0;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg <= sensor.sample;
            min_reg  <= sensor.cal_min;
            max_reg  <= sensor.cal_max;
        end

        if (div_step)
        begin
            if (take)
            begin
                rem_reg <= trial_diff[lsps_pkg::DIV_W-1:0];
            end
            else
            begin
                rem_reg <= trial_a[lsps_pkg::DIV_W-1:0];
            end
            dvd_reg <= {dvd_reg[lsps_pkg::PCT_W-2:0], 1'b0};
            quo_reg <= quo_step;
            cnt_reg <= cnt_reg - lsps_pkg::DCNT_W'(1);
        end

        unique case (state_reg)
            lsps_pkg::S_CLASS:
            begin
                if (zero_hit)
                begin
                    frac_reg <= '0;
                    pct_reg  <= '0;
                end
                else if (full_hit)
                begin
                    frac_reg <= lsps_pkg::FRAC_W'(lsps_pkg::Q12_ONE);
                    pct_reg  <= lsps_pkg::PCT_W'(lsps_pkg::FULL_PERCENT);
                end
                rem_reg     <= lsps_pkg::DIV_W'(d_val);
                divisor_reg <= lsps_pkg::DIV_W'(r_val);
                dvd_reg     <= '0;
                cnt_reg     <= lsps_pkg::DCNT_W'(lsps_pkg::FRAC_Q_W);
            end
            lsps_pkg::S_PCT_INIT:
            begin
                frac_reg <= lsps_pkg::FRAC_W'(quo_reg);
                rem_reg  <= lsps_pkg::DIV_W'(p100[lsps_pkg::P100_W-1:lsps_pkg::PCT_W]);
                dvd_reg  <= p100[lsps_pkg::PCT_W-1:0];
                cnt_reg  <= lsps_pkg::DCNT_W'(lsps_pkg::PCT_W);
            end
            lsps_pkg::S_PCT:
                if (cnt_reg == lsps_pkg::DCNT_W'(1))
                begin
                    pct_reg <= quo_step[lsps_pkg::PCT_W-1:0];
                end
            lsps_pkg::S_FRAME:
            begin
                if (fsum_reg == '0)
                begin
                    if (!on_line_reg)
                    begin
                        pos_reg <= prev_pos_reg;
                    end
                    else if (left_before_reg)
                    begin
                        pos_reg <= lsps_pkg::POS_W'(-lsps_pkg::EDGE_POS);
                    end
                    else if (right_before_reg)
                    begin
                        pos_reg <= lsps_pkg::POS_W'(lsps_pkg::EDGE_POS);
                    end
                    else
                    begin
                        pos_reg <= '0;
                    end
                end
                else
                begin
                    // quotient of 2048 or more saturates
                    if (take)
                    begin
                        quo_reg <= '1;
                    end
                    rem_reg     <= lsps_pkg::DIV_W'({ws_mag, 1'b0});
                    divisor_reg <= fsum_reg;
                    dvd_reg     <= '0;
                    cnt_reg     <= lsps_pkg::DCNT_W'(lsps_pkg::POS_Q_W);
                end
            end
            lsps_pkg::S_POS_DONE:
                pos_reg <= pos_div;
            lsps_pkg::S_MUL_P:
                acc_reg <= product;
            lsps_pkg::S_MUL_D:
                acc_reg <= acc_reg + product;
            default: ;
        endcase

        if (out_load)
        begin
            res_drive_reg <= drive_sat;
            res_pos_reg   <= pos_reg;
            res_seen_reg  <= on_line_reg;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.drive     = res_drive_reg;
    assign result.position  = res_pos_reg;
    assign result.line_seen = res_seen_reg;

endmodule

// ===== tb/sv/lsps_steer_checker.sv =====
// watches the sensor and result channels, predicts each frame's steering result and compares
`timescale 1ns / 1ps

module lsps_steer_checker
    import lsps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    lsps_sensor_if                sensor,
    lsps_result_if                result,
    output int                    steer_errors,
    output int                    steer_pending
);

    localparam int KP_RESET          = 256;
    localparam int KD_RESET          = 128;
    localparam int ZERO_MARGIN_RESET = 150;
    localparam int FULL_MARGIN_RESET = 25;
    localparam int REPORT_LIMIT      = 10;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [POS_W-1:0]   position;
        logic                      line_seen;
    } steer_t;

    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   kd;
    logic [MARGIN_W-1:0] zero_margin;
    logic [MARGIN_W-1:0] full_margin;

    int     sensor_idx;
    int     pct_weighted;
    int     frac_total;
    bit     left_lit;
    bit     right_lit;
    bit     left_lit_last;
    bit     right_lit_last;
    bit     tracking;
    int     last_pos;
    steer_t steer_q[$];

    function automatic int sensor_weight(input int idx);
        if (idx < NUM_SENSORS / 2)
        begin
            return idx - NUM_SENSORS / 2;
        end
        if (idx < (NUM_SENSORS + 1) / 2)
        begin
            return 0;
        end
        return idx - (NUM_SENSORS + 1) / 2 + 1;
    endfunction

    task automatic take_sample(input int v, input int mn, input int mx);
        int     frac;
        int     pct;
        int     d;
        int     r;
        int     pos;
        longint quot;
        longint acc;
        longint drv;
        steer_t e;
        if (v <= mn + int'(zero_margin))
        begin
            frac = 0;
            pct  = 0;
        end
        else if (v >= mx - int'(full_margin))
        begin
            frac = Q12_ONE;
            pct  = FULL_PERCENT;
        end
        else
        begin
            d = v - mn;
            r = mx - mn;
            if (r <= 0)
            begin
                frac = 0;
                pct  = 0;
            end
            else
            begin
                frac = (d * Q12_ONE) / r;
                pct  = (d * FULL_PERCENT) / r;
            end
        end
        pct_weighted += pct * sensor_weight(sensor_idx);
        frac_total   += frac;
        if (frac != 0)
        begin
            if (sensor_idx < EDGE_SPAN)
            begin
                left_lit = 1'b1;
            end
            if (sensor_idx + EDGE_SPAN >= NUM_SENSORS)
            begin
                right_lit = 1'b1;
            end
        end
        sensor_idx++;
        if (sensor_idx < NUM_SENSORS)
        begin
            return;
        end
        if (frac_total == 0)
        begin
            if (!tracking)
            begin
                pos = last_pos;
            end
            else if (left_lit_last)
            begin
                tracking = 1'b0;
                pos      = -EDGE_POS;
            end
            else if (right_lit_last)
            begin
                tracking = 1'b0;
                pos      = EDGE_POS;
            end
            else
            begin
                pos = 0;
            end
        end
        else
        begin
            tracking = 1'b1;
            quot = (longint'(pct_weighted) * Q12_ONE) / longint'(frac_total);
            if (quot < -1024)
            begin
                quot = -1024;
            end
            if (quot > 1023)
            begin
                quot = 1023;
            end
            pos = int'(quot);
        end
        acc = longint'(pos) * longint'(kp) + longint'(pos - last_pos) * longint'(kd);
        drv = acc / 256;
        if (drv < -32768)
        begin
            drv = -32768;
        end
        if (drv > 32767)
        begin
            drv = 32767;
        end
        e.drive     = DRIVE_W'(drv);
        e.position  = POS_W'(pos);
        e.line_seen = tracking;
        steer_q.push_back(e);
        last_pos       = pos;
        left_lit_last  = left_lit;
        right_lit_last = right_lit;
        left_lit       = 1'b0;
        right_lit      = 1'b0;
        pct_weighted   = 0;
        frac_total     = 0;
        sensor_idx     = 0;
    endtask

    task automatic check_result();
        steer_t e;
        if (steer_q.size() == 0)
        begin
            if (steer_errors < REPORT_LIMIT)
            begin
                $display("unexpected result at %0t: drive %0d position %0d line_seen %0b",
                         $time, result.drive, result.position, result.line_seen);
            end
            steer_errors++;
            return;
        end
        e = steer_q.pop_front();
        if (e.drive !== result.drive || e.position !== result.position ||
            e.line_seen !== result.line_seen)
        begin
            if (steer_errors < REPORT_LIMIT)
            begin
                $display("mismatch at %0t: drive exp %0d got %0d, position exp %0d got %0d,",
                         $time, e.drive, result.drive, e.position, result.position);
                $display("    line_seen exp %0b got %0b", e.line_seen, result.line_seen);
            end
            steer_errors++;
        end
    endtask

    initial
    begin
        steer_errors  = 0;
        steer_pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp             = GAIN_W'(KP_RESET);
            kd             = GAIN_W'(KD_RESET);
            zero_margin    = MARGIN_W'(ZERO_MARGIN_RESET);
            full_margin    = MARGIN_W'(FULL_MARGIN_RESET);
            sensor_idx     = 0;
            pct_weighted   = 0;
            frac_total     = 0;
            left_lit       = 1'b0;
            right_lit      = 1'b0;
            left_lit_last  = 1'b0;
            right_lit_last = 1'b0;
            tracking       = 1'b1;
            last_pos       = 0;
            steer_q.delete();
            steer_pending  = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (cfg_reg_t'(wr_index))
                    REG_PROP_GAIN:   kp = wr_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:  kd = wr_data[GAIN_W-1:0];
                    REG_LOW_MARGIN:  zero_margin = wr_data[MARGIN_W-1:0];
                    REG_HIGH_MARGIN: full_margin = wr_data[MARGIN_W-1:0];
                    default: ;
                endcase
            end
            if (sensor.valid && sensor.ready)
            begin
                take_sample(int'(sensor.sample), int'(sensor.cal_min), int'(sensor.cal_max));
            end
            if (result.valid && result.ready)
            begin
                check_result();
            end
            steer_pending = steer_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the line sensor steering testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import lsps_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 500;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;

    typedef enum int {
        FR_LINE,
        FR_LEFT,
        FR_RIGHT,
        FR_EMPTY,
        FR_NOISE
    } frame_kind_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    int                    steer_errors;
    int                    steer_pending;
    int                    cycle_count;
    int                    zero_margin_now;
    bit                    burst;
    bit                    hold_request;

    lsps_sensor_if sensor_ch();
    lsps_result_if result_ch();

    line_sensor_pd_steering DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .sensor   (sensor_ch),
        .result   (result_ch)
    );

    lsps_steer_checker u_steer_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .sensor        (sensor_ch),
        .result        (result_ch),
        .steer_errors  (steer_errors),
        .steer_pending (steer_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int stall;
        bit hold_done;
        hold_done       = 1'b0;
        result_ch.ready = 1'b0;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_request && !hold_done)
            begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (burst)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 10);
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    task automatic push_sample(input int s, input int mn, input int mx);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            sensor_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sensor_ch.valid   <= 1'b1;
        sensor_ch.sample  <= SAMPLE_BITS'(s);
        sensor_ch.cal_min <= SAMPLE_BITS'(mn);
        sensor_ch.cal_max <= SAMPLE_BITS'(mx);
        do
        begin
            @(posedge clk);
        end
        while (!sensor_ch.ready);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic set_registers(input int kp, input int kd, input int lm, input int hm);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_LOW_MARGIN, lm);
        write_reg(REG_HIGH_MARGIN, hm);
        wr_en <= 1'b0;
        zero_margin_now = lm;
        @(posedge clk);
    endtask

    // drain every pending frame result, then let the block go quiet
    task automatic settle();
        sensor_ch.valid <= 1'b0;
        @(posedge clk);
        while (steer_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(input frame_kind_t kind);
        int center;
        int width;
        int mn;
        int mx;
        int bound;
        case (kind)
            FR_LINE:
            begin
                center = $urandom_range(0, NUM_SENSORS - 1);
                width  = $urandom_range(0, 2);
            end
            FR_LEFT:
            begin
                center = $urandom_range(0, EDGE_SPAN - 1);
                width  = $urandom_range(0, 1);
            end
            FR_RIGHT:
            begin
                center = $urandom_range(NUM_SENSORS - EDGE_SPAN, NUM_SENSORS - 1);
                width  = $urandom_range(0, 1);
            end
            default:
            begin
                center = -100;
                width  = 0;
            end
        endcase
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            if (kind == FR_NOISE)
            begin
                push_sample($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                            $urandom_range(0, SAMPLE_MAX));
            end
            else
            begin
                mn = $urandom_range(0, 200);
                mx = $urandom_range(600, SAMPLE_MAX);
                if (i >= center - width && i <= center + width)
                begin
                    bound = mn + zero_margin_now + 1;
                    if (bound > SAMPLE_MAX)
                    begin
                        bound = SAMPLE_MAX;
                    end
                    push_sample($urandom_range(bound, SAMPLE_MAX), mn, mx);
                end
                else
                begin
                    bound = mn + zero_margin_now;
                    if (bound > SAMPLE_MAX)
                    begin
                        bound = SAMPLE_MAX;
                    end
                    push_sample($urandom_range(0, bound), mn, mx);
                end
            end
        end
    endtask

    // edge frames are followed by dark frames so the line gets lost and held
    task automatic run_phase(input int frames);
        int sent;
        int pick;
        int follow;
        sent = 0;
        while (sent < frames)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 4)
            begin
                send_frame(FR_LINE);
                sent++;
            end
            else if (pick <= 6)
            begin
                if (pick == 5)
                begin
                    send_frame(FR_LEFT);
                end
                else
                begin
                    send_frame(FR_RIGHT);
                end
                follow = $urandom_range(1, 3);
                repeat (follow) send_frame(FR_EMPTY);
                sent += follow + 1;
            end
            else if (pick == 7)
            begin
                send_frame(FR_EMPTY);
                sent++;
            end
            else
            begin
                send_frame(FR_NOISE);
                sent++;
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = REG_PROP_GAIN;
        wr_data           = '0;
        sensor_ch.valid   = 1'b0;
        sensor_ch.sample  = '0;
        sensor_ch.cal_min = '0;
        sensor_ch.cal_max = '0;
        burst             = 1'b0;
        hold_request      = 1'b0;
        zero_margin_now   = 150;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, threshold boundaries and inverted calibration at reset values
        push_sample(0, 0, 0);
        push_sample(1023, 0, 1023);
        push_sample(1023, 1023, 0);
        push_sample(1023, 0, 0);
        push_sample(500, 0, 1023);
        push_sample(150, 0, 1023);
        push_sample(151, 0, 1023);
        push_sample(998, 0, 1023);
        push_sample(997, 0, 1023);
        push_sample(700, 300, 900);
        push_sample(1023, 1023, 1023);
        push_sample(1000, 600, 500);
        push_sample(512, 341, 682);
        push_sample(1023, 0, 1023);
        settle();

        run_phase(20);

        set_registers(65535, 65535, 0, 0);
        burst        = 1'b1;
        hold_request = 1'b1;
        run_phase(16);
        burst = 1'b0;

        set_registers(0, 0, 1023, 1023);
        run_phase(6);

        set_registers($urandom_range(0, 65535), $urandom_range(0, 65535), 0, 1023);
        run_phase(14);

        repeat (3)
        begin
            set_registers($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 300), $urandom_range(0, 300));
            run_phase(14);
        end

        set_registers(65535, 0, 150, 25);
        run_phase(12);

        set_registers(0, 65535, 150, 25);
        run_phase(12);

        if (steer_errors == 0 && steer_pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lsps_pkg.sv
hw/rtl/lsps_if.sv
hw/rtl/line_sensor_pd_steering.sv
tb/sv/lsps_steer_checker.sv
tb/sv/tb_top.sv
